[hdl/tsb_pkg.sv]
// Package for the software timer bank: bank sizing constants, command codes,
// timer mode codes and the structs passed between the top level and the cells.
// No dependencies.
`default_nettype none

package tsb_pkg;

    // Bank sizing
    localparam int NUM_TIMERS  = 8;   // 1 to 32
    localparam int COUNT_WIDTH = 16;  // 8 to 32

    // Width of the fixed result masks
    localparam int MASK_WIDTH = 8;

    // Command codes carried on the input channel
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_RESET = 2'd3
    } tsb_cmd_code_t;

    // Per-timer mode
    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_RUNNING = 2'd1,
        MODE_START   = 2'd2,
        MODE_RESET   = 2'd3
    } tsb_mode_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic                   en;       // beat accepted this cycle
        tsb_cmd_code_t          op;
        logic [COUNT_WIDTH-1:0] value;
        logic                   restart;
    } tsb_bcast_t;

    // Masks handed from cell to cell down the chain
    typedef struct packed {
        logic [MASK_WIDTH-1:0] expired;
        logic [MASK_WIDTH-1:0] active;
    } tsb_mask_t;

endpackage

`default_nettype wire

[hdl/tsb_cell.sv]
// One timer of the bank: mode, reload value, remaining count and restart flag.
// Takes the broadcast command and shifts its status bits into the mask chain.
// Depends on tsb_pkg.
`default_nettype none

module tsb_cell
    import tsb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire tsb_bcast_t bcast,
    input  wire logic       hit,       // command addresses this timer
    input  wire tsb_mask_t  mask_in,   // from the next-higher cell
    output tsb_mask_t       mask_out   // toward cell 0
);

    tsb_mode_t              mode_reg, mode_next;
    logic [COUNT_WIDTH-1:0] reload_reg, reload_next;
    logic [COUNT_WIDTH-1:0] remaining_reg, remaining_next;
    logic                   restart_reg, restart_next;
    logic                   expire;

    // Next state for a tick or an addressed command
    always_comb
    begin
        mode_next      = mode_reg;
        reload_next    = reload_reg;
        remaining_next = remaining_reg;
        restart_next   = restart_reg;
        expire         = 1'b0;
        if (bcast.en)
        begin
            if (bcast.op == CMD_TICK)
            begin
                case (mode_reg)
                    MODE_RUNNING:
                    begin
                        if (remaining_reg == '0)
                        begin
                            expire = 1'b1;
                            if (restart_reg)
                                remaining_next = reload_reg;
                            else
                                mode_next = MODE_STOPPED;
                        end
                        else
                        begin
                            remaining_next = remaining_reg - COUNT_WIDTH'(1);
                        end
                    end
                    MODE_START:
                    begin
                        remaining_next = reload_reg;
                        mode_next      = MODE_RUNNING;
                    end
                    MODE_RESET:
                    begin
                        mode_next = MODE_START;
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
            else if (hit)
            begin
                case (bcast.op)
                    CMD_START:
                    begin
                        reload_next  = bcast.value;
                        restart_next = bcast.restart;
                        mode_next    = MODE_START;
                    end
                    CMD_STOP:
                    begin
                        mode_next = MODE_STOPPED;
                    end
                    CMD_RESET:
                    begin
                        mode_next = MODE_RESET;
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
        end
    end

    // Timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_STOPPED;
            reload_reg    <= '0;
            remaining_reg <= '0;
            restart_reg   <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            reload_reg    <= reload_next;
            remaining_reg <= remaining_next;
            restart_reg   <= restart_next;
        end
    end

    // Shift this timer's bits into the chain; bit 0 ends up as cell 0
    assign mask_out.expired = {mask_in.expired[MASK_WIDTH-2:0], expire};
    assign mask_out.active  = {mask_in.active[MASK_WIDTH-2:0], mode_next != MODE_STOPPED};

endmodule

`default_nettype wire

[hdl/software_timer_bank.sv]
// Software timer bank top level: input handshake, row of timer cells and
// result register. Depends on tsb_pkg and tsb_cell.
//
// Usage:
//   Input channel (in_valid/in_ready) carries command, timer_index,
//   load_value and auto_restart. A tick beat advances every timer; start,
//   stop and reset beats act on the addressed timer (indexes past the bank
//   are ignored). Every input beat yields exactly one result beat on the
//   output channel (out_valid/out_ready) with expired_mask and active_mask
//   for timers 0 to 7.
//   Latency: the result is valid the cycle after the input beat is taken.
//   Throughput: one beat per cycle; all timer cells update in parallel and
//   the result register is the only stage, so in_ready is high whenever the
//   result register is empty or being drained.
//   Stall: while out_valid is high and out_ready low, the result holds and
//   in_ready drops; no beat is lost or duplicated.
//   Reset: rst_n clears all timers to stopped with zero counts and empties
//   the result register. No warm-up sweep; ready right after reset.
`default_nettype none

module software_timer_bank
    import tsb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [2:0]  timer_index,
    input  wire logic [15:0] load_value,
    input  wire logic        auto_restart,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       expired_mask,
    output logic [7:0]       active_mask
);

    logic       accept;
    tsb_bcast_t bcast;
    tsb_mask_t  chain [NUM_TIMERS+1];
    logic       out_valid_reg, out_valid_next;
    tsb_mask_t  result_reg;

    // Input handshake
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Command broadcast
    assign bcast.en      = accept;
    assign bcast.op      = tsb_cmd_code_t'(command);
    assign bcast.value   = COUNT_WIDTH'(load_value);
    assign bcast.restart = auto_restart;

    // Row of timer cells, masks shifted from the top cell down to cell 0
    assign chain[NUM_TIMERS] = '0;

    for (genvar i = 0; i < NUM_TIMERS; i++)
    begin : g_cell
        logic hit;
        assign hit = (32'(timer_index) == 32'(i));

        tsb_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .bcast    (bcast),
            .hit      (hit),
            .mask_in  (chain[i+1]),
            .mask_out (chain[i])
        );
    end

    // Result register
    assign out_valid_next = accept || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= chain[0];
    end

    assign out_valid    = out_valid_reg;
    assign expired_mask = result_reg.expired;
    assign active_mask  = result_reg.active;

    // Checks
    a_beat_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted beat did not produce a result");

    a_cmd_no_expiry: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command != CMD_TICK) |=> expired_mask == '0)
        else $error("command beat reported an expiry");

    a_stop_clears_active: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == CMD_STOP && 32'(timer_index) < NUM_TIMERS
            && 32'(timer_index) < MASK_WIDTH)
        |=> !active_mask[$past(timer_index)])
        else $error("stopped timer still reported active");

    a_start_sets_active: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == CMD_START && 32'(timer_index) < NUM_TIMERS
            && 32'(timer_index) < MASK_WIDTH)
        |=> active_mask[$past(timer_index)])
        else $error("started timer not reported active");

endmodule

`default_nettype wire

[sim/tb.sv]
// Testbench for software_timer_bank: directed and random tick/start/stop/reset beats
// with idle and stall bursts; every result beat is checked against a timer-bank predictor.
// Depends on tsb_pkg and the software_timer_bank RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    // Predicted timer bank state plus the queue of masks still owed by the block
    class timer_mask_board;
        tsb_mode_t              mode   [NUM_TIMERS];
        logic [COUNT_WIDTH-1:0] reload [NUM_TIMERS];
        logic [COUNT_WIDTH-1:0] remain [NUM_TIMERS];
        bit                     rearm  [NUM_TIMERS];
        tsb_mask_t              due_masks[$];
        int                     errors;

        function new();
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                mode[i]   = MODE_STOPPED;
                reload[i] = '0;
                remain[i] = '0;
                rearm[i]  = 1'b0;
            end
            errors = 0;
        endfunction

        // Apply one accepted input beat and queue the masks it must produce
        function void take_beat(tsb_cmd_code_t op, logic [2:0] idx,
                                logic [15:0] val, logic ar);
            tsb_mask_t m;
            m.expired = '0;
            m.active  = '0;
            if (op == CMD_TICK)
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    case (mode[i])
                        MODE_RUNNING:
                        begin
                            if (remain[i] == '0)
                            begin
                                if (rearm[i])
                                    remain[i] = reload[i];
                                else
                                    mode[i] = MODE_STOPPED;
                                if (i < MASK_WIDTH)
                                    m.expired[i] = 1'b1;
                            end
                            else
                                remain[i] = remain[i] - COUNT_WIDTH'(1);
                        end
                        MODE_START:
                        begin
                            remain[i] = reload[i];
                            mode[i]   = MODE_RUNNING;
                        end
                        MODE_RESET:
                            mode[i] = MODE_START;
                        default:
                            ;
                    endcase
                end
            end
            else if (32'(idx) < NUM_TIMERS)
            begin
                // commands past the bank are dropped
                case (op)
                    CMD_START:
                    begin
                        reload[idx] = COUNT_WIDTH'(val);
                        rearm[idx]  = ar;
                        mode[idx]   = MODE_START;
                    end
                    CMD_STOP:
                        mode[idx] = MODE_STOPPED;
                    default:
                        mode[idx] = MODE_RESET;
                endcase
            end
            for (int i = 0; i < NUM_TIMERS && i < MASK_WIDTH; i++)
                m.active[i] = (mode[i] != MODE_STOPPED);
            due_masks.push_back(m);
        endfunction

        // Compare one result beat with the oldest queued masks
        function void check_masks(logic [7:0] expired, logic [7:0] active);
            tsb_mask_t want;
            if (due_masks.size() == 0)
            begin
                $error("unexpected result beat: expired_mask=%h active_mask=%h",
                       expired, active);
                errors++;
                return;
            end
            want = due_masks.pop_front();
            if (expired !== want.expired)
            begin
                $error("expired_mask: expected %h, actual %h", want.expired, expired);
                errors++;
            end
            if (active !== want.active)
            begin
                $error("active_mask: expected %h, actual %h", want.active, active);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [2:0]  timer_index;
    logic [15:0] load_value;
    logic        auto_restart;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  expired_mask;
    logic [7:0]  active_mask;

    bit              idle_on = 1'b1;
    int              quiet_cycles = 0;
    timer_mask_board board = new();

    software_timer_bank u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .timer_index  (timer_index),
        .load_value   (load_value),
        .auto_restart (auto_restart),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .expired_mask (expired_mask),
        .active_mask  (active_mask)
    );

    always #10 clk = ~clk;

    // Present one beat, with an optional idle burst first; returns once accepted
    task automatic send_beat(input tsb_cmd_code_t op, input logic [2:0] idx,
                             input logic [15:0] val, input logic ar);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= op;
        timer_index  <= idx;
        load_value   <= val;
        auto_restart <= ar;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Result side: ready with random stall bursts
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Beat monitor and watchdog; values seen here are the pre-edge ones
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            board.take_beat(tsb_cmd_code_t'(command), timer_index, load_value,
                            auto_restart);
        if (out_valid && out_ready)
            board.check_masks(expired_mask, active_mask);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Main sequence
    initial
    begin
        int            pick;
        int            vsel;
        tsb_cmd_code_t op;
        logic [15:0]   val;

        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        command      <= CMD_TICK;
        timer_index  <= '0;
        load_value   <= '0;
        auto_restart <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle bank, zero and full-scale reloads, expiry with and
        // without restart, reset and start on a running timer, stop on idle
        send_beat(CMD_TICK,  3'd0, 16'h0000, 1'b0);
        send_beat(CMD_START, 3'd0, 16'h0000, 1'b1);
        send_beat(CMD_START, 3'd7, 16'hFFFF, 1'b0);
        send_beat(CMD_START, 3'd3, 16'h0001, 1'b0);
        send_beat(CMD_TICK,  3'd7, 16'hFFFF, 1'b1);
        send_beat(CMD_TICK,  3'd0, 16'h0000, 1'b0);
        send_beat(CMD_TICK,  3'd0, 16'h0000, 1'b0);
        send_beat(CMD_RESET, 3'd0, 16'hFFFF, 1'b1);
        send_beat(CMD_TICK,  3'd0, 16'h0000, 1'b0);
        send_beat(CMD_TICK,  3'd0, 16'h0000, 1'b0);
        send_beat(CMD_TICK,  3'd0, 16'h0000, 1'b0);
        send_beat(CMD_STOP,  3'd7, 16'h1234, 1'b1);
        send_beat(CMD_STOP,  3'd5, 16'h0000, 1'b0);
        send_beat(CMD_START, 3'd0, 16'h0002, 1'b1);
        send_beat(CMD_RESET, 3'd4, 16'h0000, 1'b0);
        send_beat(CMD_START, 3'd5, 16'h5555, 1'b1);
        send_beat(CMD_START, 3'd6, 16'hAAAA, 1'b0);
        send_beat(CMD_TICK,  3'd2, 16'h0F0F, 1'b1);
        send_beat(CMD_TICK,  3'd0, 16'h0000, 1'b0);
        send_beat(CMD_TICK,  3'd0, 16'h0000, 1'b0);
        send_beat(CMD_TICK,  3'd0, 16'h0000, 1'b0);
        send_beat(CMD_TICK,  3'd0, 16'h0000, 1'b0);

        // Random: mostly short reloads so timers expire often; idling per
        // chunk, none in the final chunks
        for (int chunk = 0; chunk < 20; chunk++)
        begin
            idle_on = (chunk < 17) && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < 100; k++)
            begin
                pick = $urandom_range(0, 99);
                vsel = $urandom_range(0, 19);
                if (pick < 50)
                    op = CMD_TICK;
                else if (pick < 75)
                    op = CMD_START;
                else if (pick < 85)
                    op = CMD_STOP;
                else
                    op = CMD_RESET;
                if (vsel < 16)
                    val = 16'($urandom_range(0, 6));
                else if (vsel < 19)
                    val = 16'($urandom_range(0, 40));
                else
                    val = 16'($urandom);
                send_beat(op, 3'($urandom_range(0, 7)), val, 1'($urandom_range(0, 1)));
            end
        end
        in_valid <= 1'b0;

        // Drain outstanding results, then allow for stray beats
        do
            @(posedge clk);
        while (board.due_masks.size() != 0);
        repeat (4) @(posedge clk);
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
